/* sv/gfrl_pkg.sv */
package gfrl_pkg;

  localparam int MaxColumns = 128;
  localparam int MaxRows    = 64;
  localparam int MaxRegions = 4096;
  localparam int MaxCells   = MaxColumns * MaxRows;

  localparam int XW   = $clog2(MaxColumns);   // column index
  localparam int YW   = $clog2(MaxRows);      // row index
  localparam int CAW  = $clog2(MaxCells);     // cell address
  localparam int CNTW = CAW + 1;              // cell count
  localparam int RIW  = $clog2(MaxRegions);   // region index
  localparam int RNW  = RIW + 1;              // region count

  localparam int ColsW = 8;
  localparam int RowsW = 7;
  localparam int CfgW  = 8;

  localparam logic [ColsW-1:0] ColsReset = ColsW'(56);
  localparam logic [RowsW-1:0] RowsReset = RowsW'(38);
  localparam logic [ColsW-1:0] ColsMin   = ColsW'(8);
  localparam logic [ColsW-1:0] ColsMax   = ColsW'(MaxColumns);
  localparam logic [RowsW-1:0] RowsMin   = RowsW'(8);
  localparam logic [RowsW-1:0] RowsMax   = RowsW'(MaxRows);

  // configuration register indexes
  localparam logic CfgColumns = 1'b0;
  localparam logic CfgRows    = 1'b1;

  // input item kinds
  localparam logic KindLoad = 1'b0;
  localparam logic KindRead = 1'b1;

  typedef struct packed {
    logic [CNTW-1:0] cells;
    logic [XW-1:0]   min_x;
    logic [XW-1:0]   max_x;
    logic [YW-1:0]   min_y;
    logic [YW-1:0]   max_y;
    logic            edge_hit;
  } region_rec_t;

endpackage

/* sv/gfrl_in_if.sv */
interface gfrl_in_if;
  import gfrl_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic              cell_free;
  logic [RIW-1:0]    rank;

  modport source (output valid, kind, cell_free, rank, input ready);
  modport sink   (input valid, kind, cell_free, rank, output ready);
endinterface

/* sv/gfrl_out_if.sv */
interface gfrl_out_if;
  import gfrl_pkg::*;
  logic              valid;
  logic              ready;
  logic [RNW-1:0]    region_count;
  logic [CNTW-1:0]   total_free;
  logic              region_valid;
  logic [CNTW-1:0]   region_cells;
  logic [XW-1:0]     box_min_x;
  logic [XW-1:0]     box_max_x;
  logic [YW-1:0]     box_min_y;
  logic [YW-1:0]     box_max_y;
  logic              touches_edge;

  modport source (output valid, region_count, total_free, region_valid, region_cells,
                  box_min_x, box_max_x, box_min_y, box_max_y, touches_edge,
                  input ready);
  modport sink   (input valid, region_count, total_free, region_valid, region_cells,
                  box_min_x, box_max_x, box_min_y, box_max_y, touches_edge,
                  output ready);
endinterface

/* sv/grid_free_region_labeler_core.sv */
// Load transaction: accepted while idle, loads follow back to back; no result unless
// it is the last cell. Last cell: labeling runs the scan, the flood fill of each free
// region, the bucket prefix over sizes and the sort, then posts the result; input is
// held off until it is posted. Read transaction: the rank store and then the region
// store are read before the result is posted; a rank at or beyond the region count is
// answered without a store read. Reset: grid 56 x 38, no regions, loading at cell zero;
// the stores are rewritten by each grid load and need no clearing pass.
module grid_free_region_labeler_core
  import gfrl_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  gfrl_in_if.sink         in_i,
  gfrl_out_if.source      out_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_RD_RANK, S_RD_REC, S_RD_OUT,
    S_SCAN_RD, S_SCAN_CHK, S_SCAN_NEXT,
    S_Q_RD, S_Q_POP, S_NB_ADDR, S_NB_CHK,
    S_H_RD, S_H_BK, S_H_WR,
    S_P_RD, S_P_WR,
    S_S_RD, S_S_BK, S_S_WR,
    S_DONE, S_EMIT
  } state_e;

  state_e state_q;

  logic [ColsW-1:0] cols_q;
  logic [RowsW-1:0] rows_q;
  logic [CNTW-1:0]  load_pos_q;
  logic [RNW-1:0]   found_q;
  logic [CNTW-1:0]  free_tot_q;

  logic [XW-1:0]    sx_q;
  logic [YW-1:0]    sy_q;
  logic [CAW-1:0]   saddr_q;
  logic [CNTW-1:0]  freecnt_q;
  logic [RNW-1:0]   n_q;
  logic [CNTW-1:0]  head_q, tail_q;
  logic [XW-1:0]    cx_q, nx_q;
  logic [YW-1:0]    cy_q, ny_q;
  logic [CAW-1:0]   naddr_q;
  logic [1:0]       k_q;
  region_rec_t      rec_q;
  logic [RNW-1:0]   i_q;
  logic [CAW-1:0]   pidx_q, cidx_q;
  logic [RNW-1:0]   pos_q;
  logic [RIW-1:0]   rank_q;
  logic             res_valid_q;
  region_rec_t      res_rec_q;
  logic             out_valid_q;

  // grid size in use
  logic [ColsW-1:0] cols;
  logic [RowsW-1:0] rows;
  logic [CNTW-1:0]  total;
  logic [CNTW-1:0]  lp;
  logic [CNTW-1:0]  load_pos_d;
  logic             in_fire;

  always_comb begin
    cols = cols_q;
    if (cols_q < ColsMin) cols = ColsMin;
    if (cols_q > ColsMax) cols = ColsMax;
    rows = rows_q;
    if (rows_q < RowsMin) rows = RowsMin;
    if (rows_q > RowsMax) rows = RowsMax;
  end

  assign total   = CNTW'(cols) * CNTW'(rows);
  assign lp      = (load_pos_q >= total) ? '0 : load_pos_q;
  assign in_fire = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // next load position: a config write restarts loading, the last cell wraps to zero
  always_comb begin
    load_pos_d = load_pos_q;
    if (cfg_we_i) begin
      load_pos_d = '0;
    end else if (in_fire && in_i.kind == KindLoad) begin
      load_pos_d = (lp + CNTW'(1) == total) ? '0 : lp + CNTW'(1);
    end
  end

  // memories
  logic              map_we;
  logic [CAW-1:0]    map_waddr, map_raddr;
  logic [1:0]        map_wdata, map_rdata;     // {free, visited}
  logic              q_we;
  logic [CAW-1:0]    q_waddr;
  logic [XW+YW-1:0]  q_wdata, q_rdata;
  logic              bk_we;
  logic [CAW-1:0]    bk_waddr, bk_raddr;
  logic [RNW-1:0]    bk_wdata, bk_rdata;
  logic              rs_we;
  logic [RIW-1:0]    rs_waddr, rs_raddr;
  region_rec_t       rs_wdata, rs_rdata;
  logic              ro_we;
  logic [RIW-1:0]    ro_waddr;
  logic [RIW-1:0]    ro_wdata, ro_rdata;

  gfrl_ram #(.Width(2), .Depth(MaxCells)) u_map (
    .clk_i, .we_i(map_we), .waddr_i(map_waddr), .wdata_i(map_wdata),
    .raddr_i(map_raddr), .rdata_o(map_rdata));

  gfrl_ram #(.Width(XW+YW), .Depth(MaxCells)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(head_q[CAW-1:0]), .rdata_o(q_rdata));

  gfrl_ram #(.Width(RNW), .Depth(MaxCells)) u_bucket (
    .clk_i, .we_i(bk_we), .waddr_i(bk_waddr), .wdata_i(bk_wdata),
    .raddr_i(bk_raddr), .rdata_o(bk_rdata));

  gfrl_ram #(.Width($bits(region_rec_t)), .Depth(MaxRegions)) u_regions (
    .clk_i, .we_i(rs_we), .waddr_i(rs_waddr), .wdata_i(rs_wdata),
    .raddr_i(rs_raddr), .rdata_o(rs_rdata));

  gfrl_ram #(.Width(RIW), .Depth(MaxRegions)) u_rank (
    .clk_i, .we_i(ro_we), .waddr_i(ro_waddr), .wdata_i(ro_wdata),
    .raddr_i(rank_q), .rdata_o(ro_rdata));

  // neighbor of the current cell for direction k
  logic [XW-1:0]  nb_x;
  logic [YW-1:0]  nb_y;
  logic           nb_ok;
  logic [CAW-1:0] nb_addr;

  always_comb begin
    nb_x  = cx_q;
    nb_y  = cy_q;
    nb_ok = 1'b0;
    unique case (k_q)
      2'd0: begin nb_x = cx_q + XW'(1); nb_ok = (ColsW'(cx_q) != cols - ColsW'(1)); end
      2'd1: begin nb_x = cx_q - XW'(1); nb_ok = (cx_q != '0); end
      2'd2: begin nb_y = cy_q + YW'(1); nb_ok = (RowsW'(cy_q) != rows - RowsW'(1)); end
      default: begin nb_y = cy_q - YW'(1); nb_ok = (cy_q != '0); end
    endcase
    nb_addr = CAW'(nb_y * cols + CNTW'(nb_x));
  end

  logic start_seed, push_nb, q_empty, scan_last;
  logic [CAW-1:0] rec_cidx;

  assign start_seed = (state_q == S_SCAN_CHK) && map_rdata[1] && !map_rdata[0];
  assign push_nb    = (state_q == S_NB_CHK) && map_rdata[1] && !map_rdata[0];
  assign q_empty    = (head_q == tail_q);
  assign scan_last  = (CNTW'(saddr_q) == total - CNTW'(1));
  assign rec_cidx   = CAW'(rs_rdata.cells - CNTW'(1));

  // memory port control
  always_comb begin
    map_we    = 1'b0;
    map_waddr = lp[CAW-1:0];
    map_wdata = {in_i.cell_free, 1'b0};
    map_raddr = saddr_q;
    q_we      = 1'b0;
    q_waddr   = tail_q[CAW-1:0];
    q_wdata   = {ny_q, nx_q};
    bk_we     = 1'b0;
    bk_waddr  = lp[CAW-1:0];
    bk_wdata  = '0;
    bk_raddr  = pidx_q;
    rs_we     = (state_q == S_Q_RD) && q_empty && (n_q < RNW'(MaxRegions));
    rs_waddr  = n_q[RIW-1:0];
    rs_wdata  = rec_q;
    rs_raddr  = i_q[RIW-1:0];
    ro_we     = (state_q == S_S_WR);
    ro_waddr  = bk_rdata[RIW-1:0];
    ro_wdata  = i_q[RIW-1:0];

    if (in_fire && in_i.kind == KindLoad) begin
      map_we = 1'b1;
      bk_we  = 1'b1;
    end
    if (start_seed) begin
      map_we    = 1'b1;
      map_waddr = saddr_q;
      map_wdata = 2'b11;
      q_we      = 1'b1;
      q_waddr   = '0;
      q_wdata   = {sy_q, sx_q};
    end
    if (push_nb) begin
      map_we    = 1'b1;
      map_waddr = naddr_q;
      map_wdata = 2'b11;
      q_we      = 1'b1;
    end
    if (state_q == S_NB_ADDR) map_raddr = nb_addr;
    if (state_q == S_H_BK || state_q == S_S_BK) bk_raddr = rec_cidx;
    if (state_q == S_H_WR || state_q == S_S_WR) begin
      bk_we    = 1'b1;
      bk_waddr = cidx_q;
      bk_wdata = bk_rdata + RNW'(1);
    end
    if (state_q == S_P_WR) begin
      bk_we    = 1'b1;
      bk_waddr = pidx_q;
      bk_wdata = pos_q;
    end
    if (state_q == S_RD_REC) rs_raddr = ro_rdata;
  end

  // sequencer, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cols_q      <= ColsReset;
      rows_q      <= RowsReset;
      load_pos_q  <= '0;
      found_q     <= '0;
      free_tot_q  <= '0;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      n_q         <= '0;
    end else begin
      load_pos_q <= load_pos_d;

      // result register: a new result replaces an accepted one
      if (state_q == S_EMIT && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (in_i.kind == KindLoad) begin
              if (lp + CNTW'(1) == total) begin
                saddr_q    <= '0;
                sx_q       <= '0;
                sy_q       <= '0;
                freecnt_q  <= '0;
                n_q        <= '0;
                state_q    <= S_SCAN_RD;
              end
            end else if (RNW'(in_i.rank) < found_q) begin
              rank_q  <= in_i.rank;
              state_q <= S_RD_RANK;
            end else begin
              res_valid_q <= 1'b0;
              res_rec_q   <= '0;
              state_q     <= S_EMIT;
            end
          end
        end
        S_RD_RANK: state_q <= S_RD_REC;
        S_RD_REC:  state_q <= S_RD_OUT;
        S_RD_OUT: begin
          res_valid_q <= 1'b1;
          res_rec_q   <= rs_rdata;
          state_q     <= S_EMIT;
        end

        // raster scan for seeds
        S_SCAN_RD: state_q <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (map_rdata[1]) freecnt_q <= freecnt_q + CNTW'(1);
          if (start_seed) begin
            head_q        <= '0;
            tail_q        <= CNTW'(1);
            rec_q.cells   <= '0;
            rec_q.min_x   <= sx_q;
            rec_q.max_x   <= sx_q;
            rec_q.min_y   <= sy_q;
            rec_q.max_y   <= sy_q;
            rec_q.edge_hit <= 1'b0;
            state_q       <= S_Q_RD;
          end else begin
            state_q <= S_SCAN_NEXT;
          end
        end
        S_SCAN_NEXT: begin
          if (scan_last) begin
            i_q     <= '0;
            state_q <= (n_q == '0) ? S_DONE : S_H_RD;
          end else begin
            saddr_q <= saddr_q + CAW'(1);
            if (ColsW'(sx_q) == cols - ColsW'(1)) begin
              sx_q <= '0;
              sy_q <= sy_q + YW'(1);
            end else begin
              sx_q <= sx_q + XW'(1);
            end
            state_q <= S_SCAN_RD;
          end
        end

        // breadth-first flood fill
        S_Q_RD: begin
          if (q_empty) begin
            if (n_q < RNW'(MaxRegions)) n_q <= n_q + RNW'(1);
            state_q <= S_SCAN_NEXT;
          end else begin
            head_q  <= head_q + CNTW'(1);
            state_q <= S_Q_POP;
          end
        end
        S_Q_POP: begin
          cx_q <= q_rdata[XW-1:0];
          cy_q <= q_rdata[XW+YW-1:XW];
          rec_q.cells <= rec_q.cells + CNTW'(1);
          if (q_rdata[XW-1:0] < rec_q.min_x) rec_q.min_x <= q_rdata[XW-1:0];
          if (q_rdata[XW-1:0] > rec_q.max_x) rec_q.max_x <= q_rdata[XW-1:0];
          if (q_rdata[XW+YW-1:XW] < rec_q.min_y) rec_q.min_y <= q_rdata[XW+YW-1:XW];
          if (q_rdata[XW+YW-1:XW] > rec_q.max_y) rec_q.max_y <= q_rdata[XW+YW-1:XW];
          if (q_rdata[XW-1:0] == '0 || q_rdata[XW+YW-1:XW] == '0 ||
              ColsW'(q_rdata[XW-1:0]) == cols - ColsW'(1) ||
              RowsW'(q_rdata[XW+YW-1:XW]) == rows - RowsW'(1)) begin
            rec_q.edge_hit <= 1'b1;
          end
          k_q     <= '0;
          state_q <= S_NB_ADDR;
        end
        S_NB_ADDR: begin
          nx_q    <= nb_x;
          ny_q    <= nb_y;
          naddr_q <= nb_addr;
          if (nb_ok) begin
            state_q <= S_NB_CHK;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= (k_q == 2'd3) ? S_Q_RD : S_NB_ADDR;
          end
        end
        S_NB_CHK: begin
          if (push_nb) tail_q <= tail_q + CNTW'(1);
          k_q     <= k_q + 2'd1;
          state_q <= (k_q == 2'd3) ? S_Q_RD : S_NB_ADDR;
        end

        // histogram of region sizes
        S_H_RD: state_q <= S_H_BK;
        S_H_BK: begin
          cidx_q  <= rec_cidx;
          state_q <= S_H_WR;
        end
        S_H_WR: begin
          i_q <= i_q + RNW'(1);
          if (i_q + RNW'(1) == n_q) begin
            pidx_q  <= CAW'(total - CNTW'(1));
            pos_q   <= '0;
            state_q <= S_P_RD;
          end else begin
            state_q <= S_H_RD;
          end
        end

        // bucket starts, largest size first
        S_P_RD: state_q <= S_P_WR;
        S_P_WR: begin
          pos_q <= pos_q + bk_rdata;
          if (pidx_q == '0) begin
            i_q     <= '0;
            state_q <= S_S_RD;
          end else begin
            pidx_q  <= pidx_q - CAW'(1);
            state_q <= S_P_RD;
          end
        end

        // stable scatter into rank order
        S_S_RD: state_q <= S_S_BK;
        S_S_BK: begin
          cidx_q  <= rec_cidx;
          state_q <= S_S_WR;
        end
        S_S_WR: begin
          i_q     <= i_q + RNW'(1);
          state_q <= (i_q + RNW'(1) == n_q) ? S_DONE : S_S_RD;
        end

        S_DONE: begin
          found_q     <= n_q;
          free_tot_q  <= freecnt_q;
          res_valid_q <= 1'b0;
          res_rec_q   <= '0;
          state_q     <= S_EMIT;
        end

        S_EMIT: begin
          if (!out_valid_q || out_o.ready) begin
            out_o.region_count  <= found_q;
            out_o.total_free    <= free_tot_q;
            out_o.region_valid  <= res_valid_q;
            out_o.region_cells  <= res_rec_q.cells;
            out_o.box_min_x     <= res_rec_q.min_x;
            out_o.box_max_x     <= res_rec_q.max_x;
            out_o.box_min_y     <= res_rec_q.min_y;
            out_o.box_max_y     <= res_rec_q.max_y;
            out_o.touches_edge  <= res_rec_q.edge_hit;
            state_q             <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase

      // configuration writes
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgColumns) cols_q <= cfg_data_i[ColsW-1:0];
        else if (cfg_idx_i == CfgRows) rows_q <= cfg_data_i[RowsW-1:0];
      end
    end
  end

  assign out_o.valid = out_valid_q;

  // the queue head never passes the tail
  assert property (@(posedge clk_i) disable iff (!rst_ni) head_q <= tail_q)
    else $error("queue head passed tail");

  // every neighbor push stays inside the grid
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_nb |-> tail_q < total)
    else $error("queue push beyond grid size");

  // region counter stays within the store
  assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= RNW'(MaxRegions))
    else $error("region counter overflow");

  // a new result only comes from the emit step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("result raised outside emit");

endmodule

/* sv/gfrl_ram.sv */
module gfrl_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import gfrl_pkg::*;

  localparam int IdleLimit = 400000;

  typedef struct {
    logic           kind;
    logic           cell_free;
    logic [RIW-1:0] rank;
  } cell_cmd_t;

  typedef struct {
    logic [RNW-1:0]  region_count;
    logic [CNTW-1:0] total_free;
    logic            region_valid;
    logic [CNTW-1:0] region_cells;
    logic [XW-1:0]   box_min_x;
    logic [XW-1:0]   box_max_x;
    logic [YW-1:0]   box_min_y;
    logic [YW-1:0]   box_max_y;
    logic            touches_edge;
  } region_reply_t;

  // grid fill patterns
  typedef enum int {FillRandom, FillAll, FillNone, FillChecker, FillFrame, FillStripes} fill_e;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic            cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  gfrl_in_if  in_if ();
  gfrl_out_if out_if ();

  grid_free_region_labeler_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  cell_cmd_t     cmd_queue[$];
  region_reply_t reply_queue[$];

  int fail_count = 0;
  int n_loads = 0, n_reads = 0, n_grids = 0, n_hits = 0;

  // append one pending input transaction
  function void add_cmd(cell_cmd_t c);
    cmd_queue = {cmd_queue, c};
  endfunction

  // ---------------- labeler predictor state ----------------
  logic [ColsW-1:0] cols_reg = ColsReset;
  logic [RowsW-1:0] rows_reg = RowsReset;
  bit   free_cells[MaxCells];
  bit   seen[MaxCells];
  int   bfs_fifo[MaxCells];
  int   load_pos = 0;
  int   region_total = 0;
  int   free_sum = 0;
  int   reg_cells[MaxRegions];
  int   reg_minx[MaxRegions], reg_maxx[MaxRegions];
  int   reg_miny[MaxRegions], reg_maxy[MaxRegions];
  bit   reg_edge[MaxRegions];
  int   by_size[MaxRegions];

  function automatic int cols_used();
    int c;
    c = cols_reg;
    if (c < 8) c = 8;
    if (c > MaxColumns) c = MaxColumns;
    return c;
  endfunction

  function automatic int rows_used();
    int r;
    r = rows_reg;
    if (r < 8) r = 8;
    if (r > MaxRows) r = MaxRows;
    return r;
  endfunction

  // flood fill from raster seeds, then stable rank by size, largest first
  function void label_regions();
    int cols, rows, cells, head, tail, cur, cx, cy, nx, ny, nb, n, fc, j, k, tmp;
    cols = cols_used();
    rows = rows_used();
    cells = cols * rows;
    n = 0;
    fc = 0;
    for (int s = 0; s < MaxCells; s++) seen[s] = 0;
    for (int s = 0; s < cells; s++) begin
      if (free_cells[s]) fc++;
      if (!free_cells[s] || seen[s]) continue;
      reg_cells[n] = 0;
      reg_minx[n] = s % cols; reg_maxx[n] = s % cols;
      reg_miny[n] = s / cols; reg_maxy[n] = s / cols;
      reg_edge[n] = 0;
      seen[s] = 1;
      head = 0; tail = 0;
      bfs_fifo[tail++] = s;
      while (head < tail) begin
        cur = bfs_fifo[head++];
        cx = cur % cols; cy = cur / cols;
        reg_cells[n]++;
        if (cx < reg_minx[n]) reg_minx[n] = cx;
        if (cx > reg_maxx[n]) reg_maxx[n] = cx;
        if (cy < reg_miny[n]) reg_miny[n] = cy;
        if (cy > reg_maxy[n]) reg_maxy[n] = cy;
        if (cx == 0 || cy == 0 || cx == cols - 1 || cy == rows - 1) reg_edge[n] = 1;
        for (int d = 0; d < 4; d++) begin
          nx = cx + (d == 0 ? 1 : d == 1 ? -1 : 0);
          ny = cy + (d == 2 ? 1 : d == 3 ? -1 : 0);
          if (nx < 0 || ny < 0 || nx >= cols || ny >= rows) continue;
          nb = ny * cols + nx;
          if (free_cells[nb] && !seen[nb]) begin
            seen[nb] = 1;
            bfs_fifo[tail++] = nb;
          end
        end
      end
      if (n < MaxRegions) n++;
    end
    // stable insertion sort, descending cell count
    for (j = 0; j < n; j++) begin
      by_size[j] = j;
      k = j;
      while (k > 0 && reg_cells[by_size[k-1]] < reg_cells[by_size[k]]) begin
        tmp = by_size[k-1]; by_size[k-1] = by_size[k]; by_size[k] = tmp;
        k--;
      end
    end
    region_total = n;
    free_sum = fc;
  endfunction

  function void predict_reply(cell_cmd_t c);
    region_reply_t r;
    int cells, id;
    r = '{default: '0};
    if (c.kind == KindLoad) begin
      n_loads++;
      cells = cols_used() * rows_used();
      if (load_pos >= cells) load_pos = 0;
      free_cells[load_pos] = c.cell_free;
      load_pos++;
      if (load_pos < cells) return;
      load_pos = 0;
      label_regions();
      n_grids++;
    end else begin
      n_reads++;
      if (c.rank < region_total) begin
        id = by_size[c.rank];
        n_hits++;
        r.region_valid = 1'b1;
        r.region_cells = CNTW'(reg_cells[id]);
        r.box_min_x    = XW'(reg_minx[id]);
        r.box_max_x    = XW'(reg_maxx[id]);
        r.box_min_y    = YW'(reg_miny[id]);
        r.box_max_y    = YW'(reg_maxy[id]);
        r.touches_edge = reg_edge[id];
      end
    end
    r.region_count = RNW'(region_total);
    r.total_free   = CNTW'(free_sum);
    reply_queue = {reply_queue, r};
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    fail_count++;
  endtask

  // ---------------- clock and reset ----------------
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // ---------------- driver, monitor, watchdog ----------------
  logic in_fire = 1'b0, out_fire = 1'b0;
  int   in_gap = 0, out_stall = 0, idle_cycles = 0;
  bit   in_burst = 0, out_burst = 0;

  initial begin
    in_if.valid = 1'b0; in_if.kind = KindLoad; in_if.cell_free = 1'b0; in_if.rank = '0;
    out_if.ready = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = CfgColumns; cfg_data_i = '0;
  end

  always @(posedge clk_i) begin
    region_reply_t w, g;
    in_fire  <= in_if.valid && in_if.ready;
    out_fire <= out_if.valid && out_if.ready;
    if (out_if.valid && out_if.ready) begin
      g.region_count = out_if.region_count; g.total_free = out_if.total_free;
      g.region_valid = out_if.region_valid; g.region_cells = out_if.region_cells;
      g.box_min_x = out_if.box_min_x; g.box_max_x = out_if.box_max_x;
      g.box_min_y = out_if.box_min_y; g.box_max_y = out_if.box_max_y;
      g.touches_edge = out_if.touches_edge;
      if (reply_queue.size() == 0) begin
        $display("%0t result transaction with nothing expected", $realtime);
        fail_count++;
      end else begin
        w = reply_queue.pop_front();
        if (g.region_count !== w.region_count)
          report_mismatch("region_count", g.region_count, w.region_count);
        if (g.total_free !== w.total_free)
          report_mismatch("total_free", g.total_free, w.total_free);
        if (g.region_valid !== w.region_valid)
          report_mismatch("region_valid", g.region_valid, w.region_valid);
        if (g.region_cells !== w.region_cells)
          report_mismatch("region_cells", g.region_cells, w.region_cells);
        if (g.box_min_x !== w.box_min_x) report_mismatch("box_min_x", g.box_min_x, w.box_min_x);
        if (g.box_max_x !== w.box_max_x) report_mismatch("box_max_x", g.box_max_x, w.box_max_x);
        if (g.box_min_y !== w.box_min_y) report_mismatch("box_min_y", g.box_min_y, w.box_min_y);
        if (g.box_max_y !== w.box_max_y) report_mismatch("box_max_y", g.box_max_y, w.box_max_y);
        if (g.touches_edge !== w.touches_edge)
          report_mismatch("touches_edge", g.touches_edge, w.touches_edge);
      end
    end
    if (in_if.valid && in_if.ready)
      predict_reply('{kind: in_if.kind, cell_free: in_if.cell_free, rank: in_if.rank});
    // watchdog: cycles without any transaction
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_ni)
      idle_cycles <= 0;
    else if (idle_cycles + 1 >= IdleLimit) begin
      $display("watchdog expired after %0d idle cycles", IdleLimit);
      $display("FAILED: results differ");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // input driver
  always @(negedge clk_i) begin
    cell_cmd_t c;
    if (rst_ni && (in_fire || !in_if.valid)) begin
      if (in_gap > 0) begin
        in_if.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (cmd_queue.size() > 0) begin
        c = cmd_queue.pop_front();
        in_if.valid <= 1'b1;
        in_if.kind <= c.kind;
        in_if.cell_free <= c.cell_free;
        in_if.rank <= c.rank;
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        in_gap <= in_burst ? 0 : $urandom_range(0, 12);
      end else
        in_if.valid <= 1'b0;
    end
  end

  // result backpressure
  always @(negedge clk_i) begin
    int s;
    if (rst_ni) begin
      s = out_stall;
      if (out_fire) begin
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        s = out_burst ? 0 : $urandom_range(0, 12);
      end
      out_if.ready <= (s == 0);
      out_stall <= (s > 0) ? s - 1 : 0;
    end
  end

  // ---------------- stimulus ----------------
  task automatic wait_drained();
    while (cmd_queue.size() != 0 || in_if.valid || reply_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgColumns) cols_reg = value;
    else rows_reg = value[RowsW-1:0];
    load_pos = 0;
  endtask

  task automatic push_read(int rank);
    add_cmd('{kind: KindRead, cell_free: 1'($urandom), rank: RIW'(rank)});
  endtask

  // one whole grid; reads mixed in now and then, then a sweep of ranks
  task automatic push_grid(fill_e fill, int density, int mix_pct);
    int cols, rows, x, y;
    bit f;
    cols = cols_used();
    rows = rows_used();
    for (int i = 0; i < cols * rows; i++) begin
      x = i % cols; y = i / cols;
      case (fill)
        FillAll:     f = 1;
        FillNone:    f = 0;
        FillChecker: f = ((x + y) % 2) == 0;
        FillFrame:   f = !(x == 0 || y == 0 || x == cols - 1 || y == rows - 1);
        FillStripes: f = (y % 2) == 0;
        default:     f = $urandom_range(0, 99) < density;
      endcase
      if ($urandom_range(0, 99) < mix_pct) push_read($urandom_range(0, 40));
      add_cmd('{kind: KindLoad, cell_free: f, rank: RIW'($urandom)});
    end
    for (int r = 0; r < 4; r++) push_read(r);
    push_read($urandom_range(0, 64));
    push_read($urandom_range(0, 4095));
  endtask

  task automatic new_size(logic [CfgW-1:0] cols, logic [CfgW-1:0] rows);
    write_reg(CfgColumns, cols);
    write_reg(CfgRows, rows);
  endtask

  initial begin
    int target;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reads before any labeling
    push_read(0);
    push_read(4095);
    wait_drained();

    // directed grids: clamped sizes and special shapes
    new_size(8'd0, 8'd0);
    push_grid(FillAll, 0, 0);
    wait_drained();
    push_grid(FillNone, 0, 0);
    wait_drained();
    new_size(8'd8, 8'd8);
    push_grid(FillChecker, 0, 0);
    push_read(31); push_read(32); push_read(33);
    wait_drained();
    new_size(8'd7, 8'd9);
    push_grid(FillFrame, 0, 0);
    wait_drained();
    new_size(8'd12, 8'd9);
    push_grid(FillStripes, 0, 0);
    wait_drained();
    // partial grid, then a size write restarts loading
    for (int i = 0; i < 20; i++)
      add_cmd('{kind: KindLoad, cell_free: 1'b1, rank: '0});
    push_read(0);
    wait_drained();
    new_size(8'd8, 8'd127);
    push_grid(FillRandom, 60, 2);
    wait_drained();
    new_size(8'd128, 8'd64);
    new_size(8'd9, 8'd8);
    push_grid(FillChecker, 0, 0);
    wait_drained();

    // random grids, mostly small, up to the item budget
    target = 1550;
    while (n_loads + n_reads < target) begin
      if ($urandom_range(0, 9) == 0)
        new_size(CfgW'($urandom_range(0, 7)), {1'($urandom), 7'($urandom_range(0, 7))});
      else
        new_size(CfgW'($urandom_range(8, 16)), {1'($urandom), 7'($urandom_range(8, 12))});
      if ($urandom_range(0, 7) == 0)
        push_grid(fill_e'($urandom_range(1, 5)), 0, 5);
      else
        push_grid(FillRandom, $urandom_range(20, 85), $urandom_range(0, 8));
      if ($urandom_range(0, 5) == 0)
        for (int i = $urandom_range(1, 30); i > 0; i--)
          add_cmd('{kind: KindLoad, cell_free: 1'($urandom), rank: '0});
      wait_drained();
    end

    $display("covered %0d grids, %0d cell loads, %0d region reads (%0d hits)",
             n_grids, n_loads, n_reads, n_hits);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
